// ===== src/ptr_pkg.sv =====
// shared types, widths and codes for the page translation block
// used by the interfaces, the controller, the datapath and the top level
package ptr_pkg;

   localparam int VA_W    = 32;
   localparam int PA_W    = 20;
   localparam int TOTAL_W = 32;
   localparam int STAMP_W = 64;

   localparam int DEF_VIRTUAL_PAGES   = 64;
   localparam int DEF_PHYSICAL_FRAMES = 16;

   localparam int                  OFS_BITS_W   = 5;
   localparam logic [OFS_BITS_W-1:0] OFS_BITS_MIN = 5'd4;
   localparam logic [OFS_BITS_W-1:0] OFS_BITS_MAX = 5'd16;
   localparam logic [OFS_BITS_W-1:0] OFS_BITS_RST = 5'd12;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      REG_POLICY      = 1'b0,
      REG_OFFSET_BITS = 1'b1
   } reg_idx_type;

   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LOOKUP,
      ST_SEARCH,
      ST_EVICT,
      ST_LOAD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup_rd;
      logic hit;
      logic fault;
      logic alloc;
      logic scan_start;
      logic scan_step;
      logic evict;
      logic load;
      logic clear_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic addr_err;
      logic entry_valid;
      logic frames_left;
      logic scan_last;
      logic clear_last;
      logic out_free;
   } sts_type;

endpackage

// ===== src/ptr_if.sv =====
// request and response channel interfaces of the page translation block
// depends on ptr_pkg for the field widths
interface ptr_req_if;
   import ptr_pkg::*;

   logic            valid;
   logic            ready;
   logic [VA_W-1:0] vaddr;

   modport source (output valid, output vaddr, input ready);
   modport sink (input valid, input vaddr, output ready);
endinterface

interface ptr_rsp_if;
   import ptr_pkg::*;

   logic               valid;
   logic               ready;
   logic [PA_W-1:0]    physical_address;
   logic               miss;
   logic               address_error;
   logic [TOTAL_W-1:0] fault_total;

   modport source (output valid, output physical_address, output miss,
                   output address_error, output fault_total, input ready);
   modport sink (input valid, input physical_address, input miss,
                 input address_error, input fault_total, output ready);
endinterface

// ===== src/ptr_ram.sv =====
// generic single write port, single read port ram with registered read data
// no package dependency
module ptr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ptr_dp.sv =====
// datapath: address split, page table ram, victim scan, counters, result register
// depends on ptr_pkg, ptr_rsp_if and ptr_ram
module ptr_dp #(
   parameter int VIRTUAL_PAGES   = ptr_pkg::DEF_VIRTUAL_PAGES,
   parameter int PHYSICAL_FRAMES = ptr_pkg::DEF_PHYSICAL_FRAMES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ptr_pkg::cmd_type               cmd,
   output ptr_pkg::sts_type               sts,
   input  logic [ptr_pkg::VA_W-1:0]       req_address,
   input  logic [ptr_pkg::OFS_BITS_W-1:0] offset_bits,
   ptr_rsp_if.source                      rsp_ch
);
   import ptr_pkg::*;

   localparam int PW     = $clog2(VIRTUAL_PAGES);
   localparam int FW     = (PHYSICAL_FRAMES > 1) ? $clog2(PHYSICAL_FRAMES) : 1;
   localparam int FILL_W = $clog2(PHYSICAL_FRAMES + 1);
   localparam int ENT_W  = 1 + FW + STAMP_W;

   logic [VA_W-1:0]       addr_ff, addr_in;
   logic                  fault_ff, fault_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FW-1:0]         frame_ff, frame_in;
   logic [PW-1:0]         idx_ff, idx_in;
   logic [PW-1:0]         clr_ff, clr_in;
   logic                  found_ff, found_in;
   logic [STAMP_W-1:0]    best_stamp_ff, best_stamp_in;
   logic [PW-1:0]         best_idx_ff, best_idx_in;
   logic [FW-1:0]         best_frame_ff, best_frame_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]       rsp_phys_ff, rsp_phys_in;
   logic                  rsp_fault_ff, rsp_fault_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;

   logic [OFS_BITS_W-1:0] eff_bits;
   logic [VA_W-1:0]       vpn_full;
   logic [PW-1:0]         vpn;
   logic                  addr_err;
   logic [VA_W-1:0]       frame_sh;
   logic [VA_W-1:0]       offs;
   logic [VA_W-1:0]       phys_full;

   logic                  ram_we;
   logic [PW-1:0]         ram_waddr;
   logic [ENT_W-1:0]      ram_wdata;
   logic                  ram_re;
   logic [PW-1:0]         ram_raddr;
   logic [ENT_W-1:0]      ram_rdata;
   logic                  ent_valid;
   logic [FW-1:0]         ent_frame;
   logic [STAMP_W-1:0]    ent_stamp;
   logic                  scan_last;
   logic                  better;

   // address split
   always_comb begin
      priority if (offset_bits < OFS_BITS_MIN) begin
         eff_bits = OFS_BITS_MIN;
      end else if (offset_bits > OFS_BITS_MAX) begin
         eff_bits = OFS_BITS_MAX;
      end else begin
         eff_bits = offset_bits;
      end
   end

   assign vpn_full  = addr_ff >> eff_bits;
   assign vpn       = vpn_full[PW-1:0];
   assign addr_err  = vpn_full >= VA_W'(VIRTUAL_PAGES);
   assign frame_sh  = VA_W'(frame_ff) << eff_bits;
   assign offs      = addr_ff & ((VA_W'(1) << eff_bits) - VA_W'(1));
   assign phys_full = frame_sh | offs;

   // page table entry
   assign ent_valid = ram_rdata[ENT_W-1];
   assign ent_frame = ram_rdata[STAMP_W +: FW];
   assign ent_stamp = ram_rdata[STAMP_W-1:0];
   assign scan_last = idx_ff == PW'(VIRTUAL_PAGES - 1);
   assign better    = ent_valid && (!found_ff || ent_stamp < best_stamp_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = vpn;
      ram_wdata = {1'b1, frame_ff, stamp_ff};
      priority if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (cmd.evict) begin
         ram_we    = found_ff;
         ram_waddr = best_idx_ff;
         ram_wdata = '0;
      end else if (cmd.load) begin
         ram_we    = 1'b1;
      end else begin
         ram_we    = 1'b0;
      end
      ram_re    = cmd.lookup_rd || cmd.scan_start || (cmd.scan_step && !scan_last);
      ram_raddr = vpn;
      priority if (cmd.scan_start) begin
         ram_raddr = '0;
      end else if (cmd.scan_step) begin
         ram_raddr = idx_ff + PW'(1);
      end else begin
         ram_raddr = vpn;
      end
   end

   ptr_ram #(
      .WIDTH (ENT_W),
      .DEPTH (VIRTUAL_PAGES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state of the datapath registers
   always_comb begin
      addr_in       = addr_ff;
      fault_in      = fault_ff;
      total_in      = total_ff;
      stamp_in      = stamp_ff;
      fill_in       = fill_ff;
      frame_in      = frame_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      found_in      = found_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      best_frame_in = best_frame_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_phys_in   = rsp_phys_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_total_in  = rsp_total_ff;

      if (cmd.capture) begin
         addr_in  = req_address;
         fault_in = 1'b0;
      end
      if (cmd.hit) begin
         frame_in = ent_frame;
      end
      if (cmd.fault) begin
         fault_in = 1'b1;
         if (total_ff != '1) begin
            total_in = total_ff + TOTAL_W'(1);
         end
      end
      if (cmd.alloc) begin
         frame_in = fill_ff[FW-1:0];
         fill_in  = fill_ff + FILL_W'(1);
      end
      if (cmd.scan_start) begin
         idx_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         if (better) begin
            found_in      = 1'b1;
            best_stamp_in = ent_stamp;
            best_idx_in   = idx_ff;
            best_frame_in = ent_frame;
         end
         if (!scan_last) begin
            idx_in = idx_ff + PW'(1);
         end
      end
      if (cmd.evict) begin
         frame_in = found_ff ? best_frame_ff : '0;
      end
      if (cmd.load) begin
         stamp_in = stamp_ff + STAMP_W'(1);
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + PW'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_phys_in  = addr_err ? '0 : phys_full[PA_W-1:0];
         rsp_fault_in = fault_ff;
         rsp_err_in   = addr_err;
         rsp_total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         stamp_ff     <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         stamp_ff     <= stamp_in;
         fill_ff      <= fill_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      fault_ff      <= fault_in;
      frame_ff      <= frame_in;
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
      best_frame_ff <= best_frame_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_fault_ff  <= rsp_fault_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign sts.addr_err    = addr_err;
   assign sts.entry_valid = ent_valid;
   assign sts.frames_left = fill_ff < FILL_W'(PHYSICAL_FRAMES);
   assign sts.scan_last   = scan_last;
   assign sts.clear_last  = clr_ff == PW'(VIRTUAL_PAGES - 1);
   assign sts.out_free    = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.physical_address = rsp_phys_ff;
   assign rsp_ch.miss             = rsp_fault_ff;
   assign rsp_ch.address_error    = rsp_err_ff;
   assign rsp_ch.fault_total      = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_stamp_step : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> stamp_ff == $past(stamp_ff) + STAMP_W'(1))
      else $error("stamp counter did not advance on a page load");

   a_total_step : assert property (@(posedge clock) disable iff (reset)
      (cmd.fault && total_ff != '1) |=> total_ff == $past(total_ff) + TOTAL_W'(1))
      else $error("fault total did not count a fault");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(PHYSICAL_FRAMES))
      else $error("frame fill count beyond the frame count");
`endif

endmodule

// ===== src/ptr_ctrl.sv =====
// controller state machine: sequences lookup, allocation, victim scan and response
// depends on ptr_pkg
module ptr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ptr_pkg::policy_type policy,
   input  ptr_pkg::sts_type    sts,
   output ptr_pkg::cmd_type    cmd
);
   import ptr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.addr_err) begin
               state_in = ST_FINISH;
            end else begin
               cmd.lookup_rd = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (sts.entry_valid) begin
               cmd.hit  = 1'b1;
               state_in = (policy == POLICY_LRU) ? ST_LOAD : ST_FINISH;
            end else begin
               cmd.fault = 1'b1;
               if (sts.frames_left) begin
                  cmd.alloc = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            cmd.evict = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_scan_full : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> !sts.frames_left)
      else $error("victim scan while a frame is still free");

   a_out_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("response register overwritten while occupied");

   a_evict_order : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |-> $past(state_ff) == ST_SEARCH)
      else $error("eviction without a completed scan");
`endif

endmodule

// ===== src/page_translate_with_replacement_top.sv =====
// paths from request to response: address error, hit (with a stamp update under lru),
// fault on a free frame, fault with eviction (one entry scanned per cycle)
// throughput: one request at a time, the next is taken once the response is registered
// reset: synchronous; a clearing pass over every page table entry follows reset
// and holds off requests, register writes are taken throughout
// top level: apb register port, controller and datapath; depends on ptr_pkg and ptr_if
module page_translate_with_replacement_top #(
   parameter int VIRTUAL_PAGES   = ptr_pkg::DEF_VIRTUAL_PAGES,
   parameter int PHYSICAL_FRAMES = ptr_pkg::DEF_PHYSICAL_FRAMES
) (
   input  logic                           clock,
   input  logic                           reset,
   ptr_req_if.sink                        req_ch,
   ptr_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ptr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ptr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ptr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import ptr_pkg::*;

   policy_type            policy_ff, policy_in;
   logic [OFS_BITS_W-1:0] ofs_bits_ff, ofs_bits_in;
   reg_idx_type           reg_idx;
   logic                  csr_wr;
   cmd_type               cmd;
   sts_type               sts;
   logic                  req_ready;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      policy_in   = policy_ff;
      ofs_bits_in = ofs_bits_ff;
      prdata      = '0;
      unique case (reg_idx)
         REG_POLICY: begin
            prdata = CSR_DATA_W'(policy_ff);
            if (csr_wr) begin
               policy_in = policy_type'(pwdata[0]);
            end
         end
         REG_OFFSET_BITS: begin
            prdata = CSR_DATA_W'(ofs_bits_ff);
            if (csr_wr) begin
               ofs_bits_in = pwdata[OFS_BITS_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_FIFO;
         ofs_bits_ff <= OFS_BITS_RST;
      end else begin
         policy_ff   <= policy_in;
         ofs_bits_ff <= ofs_bits_in;
      end
   end

   assign req_ch.ready = req_ready;

   ptr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .policy    (policy_ff),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptr_dp #(
      .VIRTUAL_PAGES   (VIRTUAL_PAGES),
      .PHYSICAL_FRAMES (PHYSICAL_FRAMES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_address (req_ch.vaddr),
      .offset_bits (ofs_bits_ff),
      .rsp_ch      (rsp_ch)
   );

endmodule
